/* rtl/orb_pkg.sv */
`default_nettype none
package orb_pkg;

   localparam int DEF_DEPTH      = 64;
   localparam int SAMPLE_W       = 16;
   localparam int POS_W          = 6;
   localparam int CNT_W          = 7;
   localparam int RING_LEN_RESET = 64;

   typedef enum logic [1:0] {
      REQ_PUSH   = 2'd0,
      REQ_READ   = 2'd1,
      REQ_REMOVE = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_RANGE   = 2'd1,
      ST_IGNORED = 2'd2
   } status_type;

   // Per-request outcome handed from the pointer logic to the result stage
   typedef struct packed {
      status_type       status;
      logic [CNT_W-1:0] count;
      logic             rd_ok;
   } result_type;

endpackage
`default_nettype wire

/* rtl/orb_mem.sv */
`default_nettype none
module orb_mem #(
   parameter int DEPTH = orb_pkg::DEF_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              wr_en,
   input  wire logic [$clog2(DEPTH)-1:0]          wr_addr,
   input  wire logic signed [orb_pkg::SAMPLE_W-1:0] wr_data,
   input  wire logic                              rd_en,
   input  wire logic [$clog2(DEPTH)-1:0]          rd_addr,
   output logic signed [orb_pkg::SAMPLE_W-1:0]    rd_data_ff
);
   import orb_pkg::*;

   logic signed [SAMPLE_W-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Hold the last read until the next read request
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

/* rtl/orb_ptr.sv */
`default_nettype none
module orb_ptr #(
   parameter int DEPTH = orb_pkg::DEF_DEPTH
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_wr_en,
   input  wire logic [orb_pkg::CNT_W-1:0]         csr_wr_data,
   input  wire logic                              accept,
   input  wire orb_pkg::req_kind_type             req_kind,
   input  wire logic [orb_pkg::POS_W-1:0]         read_position,
   input  wire logic [orb_pkg::CNT_W-1:0]         drop_amount,
   output logic                                   mem_we,
   output logic [$clog2(DEPTH)-1:0]               mem_waddr,
   output logic                                   mem_re,
   output logic [$clog2(DEPTH)-1:0]               mem_raddr,
   output orb_pkg::result_type                    result
);
   import orb_pkg::*;

   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int LEN_W   = ADDR_W + 1;
   localparam int SUM_W   = ((ADDR_W > CNT_W) ? ADDR_W : CNT_W) + 1;
   localparam int LEN_RST = (DEPTH < RING_LEN_RESET) ? DEPTH : RING_LEN_RESET;

   logic [LEN_W-1:0]  len_ff,    len_in;
   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] old_ptr_ff, old_ptr_in;
   logic [CNT_W-1:0]  count_ff,  count_in;

   logic [SUM_W-1:0] len_ext, wr_ext, old_ext, cnt_ext, pos_ext, drop_ext, csr_ext;
   logic [SUM_W-1:0] wr_inc, old_inc, old_pos, old_drop;

   function automatic logic [SUM_W-1:0] wrap_once(input logic [SUM_W-1:0] a,
                                                  input logic [SUM_W-1:0] n);
      return (a >= n) ? a - n : a;
   endfunction

   assign len_ext  = SUM_W'(len_ff);
   assign wr_ext   = SUM_W'(wr_ptr_ff);
   assign old_ext  = SUM_W'(old_ptr_ff);
   assign cnt_ext  = SUM_W'(count_ff);
   assign pos_ext  = SUM_W'(read_position);
   assign drop_ext = SUM_W'(drop_amount);
   assign csr_ext  = SUM_W'(csr_wr_data);

   assign wr_inc   = wrap_once(wr_ext + SUM_W'(1), len_ext);
   assign old_inc  = wrap_once(old_ext + SUM_W'(1), len_ext);
   assign old_pos  = wrap_once(old_ext + pos_ext, len_ext);
   assign old_drop = wrap_once(old_ext + drop_ext, len_ext);

   always_comb begin
      len_in        = len_ff;
      wr_ptr_in     = wr_ptr_ff;
      old_ptr_in    = old_ptr_ff;
      count_in      = count_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = wr_ptr_ff;
      mem_raddr     = ADDR_W'(old_pos);
      result.status = ST_OK;
      result.rd_ok  = 1'b0;

      if (csr_wr_en) begin
         // Clamp the length to 1..DEPTH and empty the ring
         if (csr_ext == '0) begin
            len_in = LEN_W'(1);
         end else if (csr_ext > SUM_W'(DEPTH)) begin
            len_in = LEN_W'(DEPTH);
         end else begin
            len_in = LEN_W'(csr_ext);
         end
         wr_ptr_in  = '0;
         old_ptr_in = '0;
         count_in   = '0;
      end else if (accept) begin
         unique case (req_kind)
            REQ_PUSH: begin
               mem_we    = 1'b1;
               wr_ptr_in = ADDR_W'(wr_inc);
               if (cnt_ext < len_ext) begin
                  count_in = count_ff + CNT_W'(1);
               end else begin
                  old_ptr_in = ADDR_W'(old_inc);
               end
            end
            REQ_READ: begin
               if (pos_ext < cnt_ext) begin
                  mem_re       = 1'b1;
                  result.rd_ok = 1'b1;
               end else begin
                  result.status = ST_RANGE;
               end
            end
            REQ_REMOVE: begin
               if (drop_ext < cnt_ext) begin
                  old_ptr_in = ADDR_W'(old_drop);
                  count_in   = count_ff - drop_amount;
               end else begin
                  result.status = ST_IGNORED;
               end
            end
            REQ_CLEAR: begin
               count_in  = '0;
               wr_ptr_in = old_ptr_ff;
            end
            default: begin
            end
         endcase
      end
      result.count = count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= LEN_W'(LEN_RST);
         wr_ptr_ff  <= '0;
         old_ptr_ff <= '0;
         count_ff   <= '0;
      end else begin
         len_ff     <= len_in;
         wr_ptr_ff  <= wr_ptr_in;
         old_ptr_ff <= old_ptr_in;
         count_ff   <= count_in;
      end
   end

endmodule
`default_nettype wire

/* rtl/overwrite_ring_buffer_unit.sv */
`default_nettype none
// Overwrite-oldest ring of signed 16-bit samples. One request (push, read at
// an offset from the oldest entry, remove oldest entries, clear) is taken
// every cycle unless rsp_tready stalls the pipe, and each gives exactly one
// response: the pointer and count update plus the sample memory access (one
// write port, one registered read port) happen at the request transfer, a
// first-stage register holds the outcome and the response register follows.
// A full ring overwrites its oldest entry on a push. Writing csr_wr_data
// sets the ring length (0 acts as 1, values above DEPTH act as DEPTH) and
// empties the ring; write it only while no response is outstanding.
module overwrite_ring_buffer_unit #(
   parameter int DEPTH = orb_pkg::DEF_DEPTH
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // [15:0] sample_value, [21:16] read_position, [28:22] drop_amount
   input  wire logic [31:0]               req_tdata,
   // [1:0] req_type
   input  wire logic [1:0]                req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // [15:0] read_data, [17:16] status, [24:18] fill_count, [25] is_empty
   output logic [31:0]                    rsp_tdata,
   input  wire logic                      csr_wr_en,
   input  wire logic [orb_pkg::CNT_W-1:0] csr_wr_data
);
   import orb_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic                       req_accept;
   logic                       s1_valid_ff, s1_valid_in;
   result_type                 s1_res_ff;
   result_type                 cur_res;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [31:0]                rsp_data_ff;
   logic                       s2_load;
   logic                       mem_we, mem_re;
   logic [ADDR_W-1:0]          mem_waddr, mem_raddr;
   logic signed [SAMPLE_W-1:0] mem_rdata;
   logic signed [SAMPLE_W-1:0] out_sample;

   assign s2_load    = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s2_load;
   assign req_accept = req_tvalid && req_tready;

   orb_ptr #(.DEPTH(DEPTH)) u_ptr (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .accept        (req_accept),
      .req_kind      (req_kind_type'(req_tuser[1:0])),
      .read_position (req_tdata[21:16]),
      .drop_amount   (req_tdata[28:22]),
      .mem_we        (mem_we),
      .mem_waddr     (mem_waddr),
      .mem_re        (mem_re),
      .mem_raddr     (mem_raddr),
      .result        (cur_res)
   );

   orb_mem #(.DEPTH(DEPTH)) u_mem (
      .clock      (clock),
      .wr_en      (mem_we),
      .wr_addr    (mem_waddr),
      .wr_data    (req_tdata[15:0]),
      .rd_en      (mem_re),
      .rd_addr    (mem_raddr),
      .rd_data_ff (mem_rdata)
   );

   assign s1_valid_in  = req_accept || (s1_valid_ff && !s2_load);
   assign rsp_valid_in = s2_load || (rsp_valid_ff && !rsp_tready);
   assign out_sample   = s1_res_ff.rd_ok ? mem_rdata : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (req_accept) begin
         s1_res_ff <= cur_res;
      end
      if (s2_load) begin
         rsp_data_ff <= {6'd0, (s1_res_ff.count == '0), s1_res_ff.count,
                         s1_res_ff.status, out_sample};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_accept_fills_stage : assert property (@(posedge clock) disable iff (reset)
      req_accept |=> s1_valid_ff)
      else $error("accepted request did not reach the first stage");

   a_stage_not_dropped : assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s2_load) |=> s1_valid_ff)
      else $error("stalled request lost from the first stage");

   a_range_reads_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[17:16] != ST_OK) |-> (rsp_tdata[15:0] == 16'd0))
      else $error("nonzero read data on a failed request");

   a_empty_flag : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[25] == (rsp_tdata[24:18] == 7'd0)))
      else $error("empty flag disagrees with fill count");

endmodule
`default_nettype wire

/* dv/ring_checker.sv */
module ring_checker (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   input  logic                      req_tready,
   input  logic [31:0]               req_tdata,
   input  logic [1:0]                req_tuser,
   input  logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   input  logic [31:0]               rsp_tdata,
   input  logic                      csr_wr_en,
   input  logic [orb_pkg::CNT_W-1:0] csr_wr_data,
   output int                        outstanding,
   output int                        mismatches
);
   import orb_pkg::*;

   localparam int DEPTH = DEF_DEPTH;

   // packed from the top bit down, so it lines up with rsp_tdata[25:0]
   typedef struct packed {
      logic                empty;
      logic [CNT_W-1:0]    fill;
      status_type          status;
      logic [SAMPLE_W-1:0] read_data;
   } ring_result_type;

   logic [SAMPLE_W-1:0] ring_mem [DEPTH];
   int                  wr_slot;
   int                  oldest_slot;
   int                  fill_level;
   int                  ring_slots;
   ring_result_type     pending_results[$];

   function automatic int wrap_slot(input int a);
      return (a >= ring_slots) ? a - ring_slots : a;
   endfunction

   // advance the shadow ring by one request and return its response
   function automatic ring_result_type apply_request(input req_kind_type kind,
                                                     input logic [SAMPLE_W-1:0] sample,
                                                     input int pos,
                                                     input int drop);
      ring_result_type res;
      res = '0;
      res.status = ST_OK;
      case (kind)
         REQ_PUSH: begin
            ring_mem[wr_slot] = sample;
            wr_slot = wrap_slot(wr_slot + 1);
            if (fill_level < ring_slots) fill_level++;
            else oldest_slot = wrap_slot(oldest_slot + 1);
         end
         REQ_READ: begin
            if (pos < fill_level) res.read_data = ring_mem[wrap_slot(oldest_slot + pos)];
            else res.status = ST_RANGE;
         end
         REQ_REMOVE: begin
            if (drop < fill_level) begin
               oldest_slot = wrap_slot(oldest_slot + drop);
               fill_level -= drop;
            end else begin
               res.status = ST_IGNORED;
            end
         end
         default: begin
            // clear keeps the oldest index, write index follows it
            fill_level = 0;
            wr_slot = oldest_slot;
         end
      endcase
      res.fill  = CNT_W'(fill_level);
      res.empty = (fill_level == 0);
      return res;
   endfunction

   task automatic report_mismatch(input string field, input int got, input int want);
      $display("%0t: rsp %s mismatch, got 0x%0h want 0x%0h", $time, field, got, want);
      mismatches++;
   endtask

   always @(posedge clock) begin
      ring_result_type want;
      ring_result_type got;
      if (reset) begin
         wr_slot     = 0;
         oldest_slot = 0;
         fill_level  = 0;
         ring_slots  = RING_LEN_RESET;
         pending_results.delete();
      end else begin
         if (csr_wr_en) begin
            ring_slots  = (csr_wr_data == 0) ? 1 :
                          (csr_wr_data > DEPTH) ? DEPTH : int'(csr_wr_data);
            wr_slot     = 0;
            oldest_slot = 0;
            fill_level  = 0;
         end
         // check the response first so a same-edge request cannot mask a stray one
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[25:0];
            if (pending_results.size() == 0) begin
               report_mismatch("transfer with nothing pending", int'(rsp_tdata), 0);
            end else begin
               want = pending_results.pop_front();
               if (got.read_data != want.read_data)
                  report_mismatch("read_data", int'(got.read_data), int'(want.read_data));
               if (got.status != want.status)
                  report_mismatch("status", int'(got.status), int'(want.status));
               if (got.fill != want.fill)
                  report_mismatch("fill_count", int'(got.fill), int'(want.fill));
               if (got.empty != want.empty)
                  report_mismatch("is_empty", int'(got.empty), int'(want.empty));
            end
         end
         if (req_tvalid && req_tready)
            pending_results.push_back(apply_request(req_kind_type'(req_tuser),
                                                     req_tdata[15:0],
                                                     int'(req_tdata[21:16]),
                                                     int'(req_tdata[28:22])));
      end
      outstanding = pending_results.size();
   end

endmodule

/* dv/tb_top.sv */
module tb_top;
   import orb_pkg::*;

   logic              clock = 1'b0;
   logic              reset;
   logic              req_tvalid;
   logic              req_tready;
   logic [31:0]       req_tdata;
   logic [1:0]        req_tuser;
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [31:0]       rsp_tdata;
   logic              csr_wr_en;
   logic [CNT_W-1:0]  csr_wr_data;
   int                outstanding;
   int                mismatches;

   bit                calm_phase;
   int                active_len;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   overwrite_ring_buffer_unit uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   ring_checker ring_chk (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .outstanding (outstanding),
      .mismatches  (mismatches)
   );

   // no gap in a calm phase; else mostly back-to-back, sometimes a short gap, rarely a long stall
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (calm_phase || r < 55) return 0;
      if (r < 85) return $urandom_range(1, 2);
      if (r < 95) return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   task automatic send_request(input req_kind_type kind, input int sample,
                               input int pos, input int drop);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= {3'b000, 7'(drop), 6'(pos), 16'(sample)};
      // ready is settled by the falling edge; the transfer lands on the next rise
      do @(negedge clock); while (!req_tready);
      @(posedge clock);
      gap = idle_len();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock); while (outstanding != 0);
      @(posedge clock);
   endtask

   task automatic set_ring_length(input logic [CNT_W-1:0] value);
      req_tvalid <= 1'b0;
      wait_drained();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      active_len = (value == 0) ? 1 : (value > DEF_DEPTH) ? DEF_DEPTH : int'(value);
   endtask

   task automatic random_traffic(input int budget);
      int sent;
      int r;
      int burst;
      int pos;
      int drop;
      sent = 0;
      while (sent < budget) begin
         r = $urandom_range(0, 99);
         if (r < 35) begin
            // push bursts can fill the ring and drive it into overwrite
            burst = $urandom_range(1, active_len + 8);
            repeat (burst) send_request(REQ_PUSH, $urandom, $urandom, $urandom);
            sent += burst;
         end else begin
            if (r < 75) begin
               pos = ($urandom_range(0, 9) < 7) ? $urandom_range(0, active_len - 1)
                                                 : $urandom_range(0, 63);
               send_request(REQ_READ, $urandom, pos, $urandom);
            end else if (r < 97) begin
               r = $urandom_range(0, 9);
               drop = (r < 5) ? $urandom_range(0, 3) :
                      (r < 8) ? $urandom_range(0, active_len) : $urandom_range(0, 127);
               send_request(REQ_REMOVE, $urandom, $urandom, drop);
            end else begin
               send_request(REQ_CLEAR, $urandom, $urandom, $urandom);
            end
            sent++;
         end
      end
   endtask

   initial begin
      rsp_tready <= 1'b0;
      @(posedge clock);
      forever begin
         int gap;
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         gap = idle_len();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   end

   initial begin
      logic [CNT_W-1:0] ring_cfg [8];
      int budget [8];
      ring_cfg = '{7'd1, 7'd0, 7'd64, 7'd127, 7'd65, 7'd2, 7'd37, 7'd0};
      budget   = '{50, 50, 200, 150, 60, 60, 100, 80};
      reset       <= 1'b1;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= REQ_PUSH;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      calm_phase  = 1'b0;
      active_len  = RING_LEN_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // short ring so full, overwrite and wrap show up quickly
      set_ring_length(7'd3);
      send_request(REQ_READ,   $urandom, 0,  $urandom);
      send_request(REQ_REMOVE, $urandom, $urandom, 0);
      send_request(REQ_CLEAR,  $urandom, $urandom, $urandom);
      send_request(REQ_PUSH,   'h7FFF, $urandom, $urandom);
      send_request(REQ_PUSH,   'h8000, $urandom, $urandom);
      send_request(REQ_PUSH,   'hFFFF, $urandom, $urandom);
      send_request(REQ_PUSH,   'h0000, $urandom, $urandom);
      send_request(REQ_READ,   $urandom, 0,  $urandom);
      send_request(REQ_READ,   $urandom, 2,  $urandom);
      send_request(REQ_READ,   $urandom, 3,  $urandom);
      send_request(REQ_READ,   $urandom, 63, $urandom);
      send_request(REQ_REMOVE, $urandom, $urandom, 3);
      send_request(REQ_REMOVE, $urandom, $urandom, 127);
      send_request(REQ_REMOVE, $urandom, $urandom, 64);
      send_request(REQ_REMOVE, $urandom, $urandom, 0);
      send_request(REQ_REMOVE, $urandom, $urandom, 2);
      send_request(REQ_READ,   $urandom, 0,  $urandom);
      send_request(REQ_PUSH,   'h5A5A, $urandom, $urandom);
      send_request(REQ_PUSH,   'hA5A5, $urandom, $urandom);
      send_request(REQ_CLEAR,  $urandom, $urandom, $urandom);
      send_request(REQ_READ,   $urandom, 0,  $urandom);
      send_request(REQ_PUSH,   'h1234, $urandom, $urandom);
      send_request(REQ_READ,   $urandom, 0,  $urandom);

      for (int phase = 0; phase < 8; phase++) begin
         if (phase == 7) ring_cfg[phase] = CNT_W'($urandom_range(1, 64));
         set_ring_length(ring_cfg[phase]);
         calm_phase = (phase % 3 == 1);
         random_traffic(budget[phase]);
      end
      calm_phase = 1'b0;

      req_tvalid <= 1'b0;
      wait_drained();
      repeat (4) @(posedge clock);
      if (mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

/* files.f */
rtl/orb_pkg.sv
rtl/orb_mem.sv
rtl/orb_ptr.sv
rtl/overwrite_ring_buffer_unit.sv
dv/ring_checker.sv
dv/tb_top.sv
